FILE: hdl/wewa_pkg.sv
// Shared constants, types and ring arithmetic for the windowed weighted pitch average.
`default_nettype none

package wewa_pkg;

	// Ring depth of the sample history.
	localparam int HISTORY_DEPTH = 16;
	localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

	// Field widths.
	localparam int IN_FREQ_W  = 20;
	localparam int FREQ_W     = 19;
	localparam int TIME_W     = 32;
	localparam int WIN_W      = 10;
	localparam int MINS_W     = 5;
	localparam int HELD_OUT_W = 5;
	localparam int CMP_W      = (CNT_W > MINS_W) ? CNT_W : MINS_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd1;
	localparam logic [WIN_W-1:0]     WINDOW_RESET    = 10'd500;
	localparam logic [MINS_W-1:0]    MIN_RESET       = 5'd3;

	// Weight table: Q0.16 weights indexed by age in milliseconds.
	localparam int AGE_SPAN = 1024;
	localparam int AGE_W    = $clog2(AGE_SPAN);
	localparam int WT_W     = 16;
	localparam logic [WT_W-1:0] WT_MAX    = '1;
	localparam logic [31:0]     DECAY_Q32 = 32'd4286385946;

	// Accumulator widths.
	localparam int PROD_W = WT_W + FREQ_W;
	localparam int SUM_W  = PROD_W + CNT_W;
	localparam int TOT_W  = WT_W + CNT_W;
	localparam int QCNT_W = $clog2(FREQ_W + 1);

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [TIME_W-1:0] stamp;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AGE_RD,
		ST_AGE_CHK,
		ST_STORE,
		ST_SUM_RD,
		ST_SUM_AGE,
		ST_SUM_MUL,
		ST_SUM_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DONE
	} wewa_state_t;

	// Ring position base + off, wrapped at the history depth.
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(HISTORY_DEPTH)) begin
			s = s - (CNT_W+1)'(HISTORY_DEPTH);
		end
		return s[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/windowed_exp_weighted_average_core.sv
// Top level: time-windowed exponentially weighted average of a pitch stream.
//
// Channel   Direction  Handshake                  Words carried
// -------   ---------  -------------------------  -------------------------------------
// sample    in         sample_valid/sample_stall  frequency (s20 Q11.8), now_ms (u32)
// result    out        result_valid/result_stall  smoothed_frequency (u19), entries_held
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// After reset the weight table is filled, one age after another over 1024 ages,
// and no sample word is taken until it is full; configuration writes are taken
// at any time. An averaged sample word first ages out the expired samples and
// stores the new one; then each held sample passes the history RAM, the weight
// RAM and the shared multiplier in turn, and the serial divider works out the
// quotient bit by bit. A no-signal word clears the history and goes straight to
// the output stage. A finished result moves into the output register, so a new
// sample word is taken while the result channel is stalled; a second finished
// result then waits, and the sample input stalls until the first is taken.
`default_nettype none

module windowed_exp_weighted_average_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Sample channel.
	input  wire logic                                   sample_valid,
	output logic                                        sample_stall,
	input  wire logic signed [wewa_pkg::IN_FREQ_W-1:0]  frequency,
	input  wire logic        [wewa_pkg::TIME_W-1:0]     now_ms,
	// Result channel.
	output logic                                        result_valid,
	input  wire logic                                   result_stall,
	output logic             [wewa_pkg::FREQ_W-1:0]     smoothed_frequency,
	output logic             [wewa_pkg::HELD_OUT_W-1:0] entries_held,
	// Configuration channel.
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic        [wewa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [wewa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wewa_pkg::*;

	wewa_state_t state_q, state_d;

	// Configuration registers.
	logic [WIN_W-1:0]  window_q;
	logic [MINS_W-1:0] min_q;

	// Ring bookkeeping.
	logic [CNT_W-1:0]  held_q;
	logic [SLOT_W-1:0] oldest_q;

	// Current sample word.
	logic [FREQ_W-1:0] freq_q;
	logic [TIME_W-1:0] now_q;

	// Weighted sum pass.
	logic [CNT_W-1:0]  idx_q;
	logic [FREQ_W-1:0] hfreq_q;
	logic              in_range_q;
	logic [PROD_W-1:0] prod_q;
	logic [WT_W-1:0]   w_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TOT_W-1:0]  tot_q;
	logic [FREQ_W-1:0] res_q;

	// Output register.
	logic                  result_valid_q;
	logic [FREQ_W-1:0]     out_freq_q;
	logic [HELD_OUT_W-1:0] out_held_q;

	// History RAM and its ports.
	logic              hist_we;
	logic [SLOT_W-1:0] hist_waddr;
	logic [SLOT_W-1:0] hist_raddr;
	hist_t             hist_wdata;
	hist_t             hist_rd;
	logic [HIST_W-1:0] hist_rdata;

	// Weight table and divider.
	logic              tab_ready;
	logic [WT_W-1:0]   wt_rdata;
	logic              div_start;
	logic [FREQ_W-1:0] div_quo;
	div_stat_t         div_stat;

	// Decodes.
	logic              accept;
	logic              nosig_in;
	logic [TIME_W-1:0] age;
	logic              too_old;
	logic              full;
	logic [SLOT_W-1:0] store_base;
	logic [CNT_W-1:0]  store_cnt;
	logic [CNT_W-1:0]  new_held;
	logic              below_min;
	logic              last_idx;
	logic              out_load;
	logic [WT_W-1:0]   w_eff;

	assign hist_rd = hist_t'(hist_rdata);

	always_comb begin
		accept   = sample_valid && !sample_stall;
		// Zero or a set sign bit means no pitch was detected.
		nosig_in = (frequency == '0) || frequency[IN_FREQ_W-1];

		// Age of whatever sample the history RAM returned this cycle.
		age     = now_q - hist_rd.stamp;
		too_old = age > TIME_W'(window_q);

		// Storing into a full ring first drops the oldest sample.
		full       = held_q == CNT_W'(HISTORY_DEPTH);
		store_base = full ? slot_add(oldest_q, CNT_W'(1)) : oldest_q;
		store_cnt  = full ? held_q - 1'b1 : held_q;
		new_held   = store_cnt + 1'b1;
		below_min  = CMP_W'(new_held) < CMP_W'(min_q);

		last_idx = idx_q == held_q - 1'b1;
		out_load = !result_valid_q || !result_stall;
		w_eff    = in_range_q ? wt_rdata : '0;

		hist_waddr       = slot_add(store_base, store_cnt);
		hist_wdata.freq  = freq_q;
		hist_wdata.stamp = now_q;
		hist_raddr       = (state_q == ST_SUM_RD) ? slot_add(oldest_q, idx_q) : oldest_q;
	end

	// Sequencer: aging walk, store, weighted sum walk, divide.
	always_comb begin
		state_d   = state_q;
		hist_we   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = nosig_in ? ST_DONE : ST_AGE_RD;
				end
			end
			ST_AGE_RD: begin
				state_d = (held_q == '0) ? ST_STORE : ST_AGE_CHK;
			end
			ST_AGE_CHK: begin
				state_d = too_old ? ST_AGE_RD : ST_STORE;
			end
			ST_STORE: begin
				hist_we = 1'b1;
				state_d = below_min ? ST_DONE : ST_SUM_RD;
			end
			ST_SUM_RD:  state_d = ST_SUM_AGE;
			ST_SUM_AGE: state_d = ST_SUM_MUL;
			ST_SUM_MUL: state_d = ST_SUM_ACC;
			ST_SUM_ACC: begin
				state_d = last_idx ? ST_DIV_START : ST_SUM_RD;
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; a write lands whenever the channel offers a word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			min_q    <= MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_MS:   window_q <= cfg_data[WIN_W-1:0];
				REG_MIN_SAMPLES: min_q    <= cfg_data[MINS_W-1:0];
				default: ;
			endcase
		end
	end

	// Ring bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= '0;
			oldest_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && accept && nosig_in) begin
				held_q   <= '0;
				oldest_q <= '0;
			end else if (state_q == ST_AGE_CHK && too_old) begin
				held_q   <= held_q - 1'b1;
				oldest_q <= slot_add(oldest_q, CNT_W'(1));
			end else if (state_q == ST_STORE) begin
				held_q   <= new_held;
				oldest_q <= store_base;
			end

			if (state_q == ST_DONE && out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				freq_q <= frequency[FREQ_W-1:0];
				now_q  <= now_ms;
				res_q  <= '0;
			end
			ST_STORE: begin
				res_q <= freq_q;
				idx_q <= '0;
				sum_q <= '0;
				tot_q <= '0;
			end
			ST_SUM_AGE: begin
				// Weight RAM address is taken from this age in the same cycle.
				hfreq_q    <= hist_rd.freq;
				in_range_q <= age < TIME_W'(AGE_SPAN);
			end
			ST_SUM_MUL: begin
				prod_q <= PROD_W'(w_eff) * PROD_W'(hfreq_q);
				w_q    <= w_eff;
			end
			ST_SUM_ACC: begin
				sum_q <= sum_q + SUM_W'(prod_q);
				tot_q <= tot_q + TOT_W'(w_q);
				idx_q <= idx_q + 1'b1;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					res_q <= (tot_q == '0) ? freq_q : div_quo;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_freq_q <= res_q;
					out_held_q <= held_q[HELD_OUT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	wewa_ram #(
		.WIDTH(HIST_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	wewa_wtab u_wtab (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(age[AGE_W-1:0]),
		.rd_data(wt_rdata),
		.ready  (tab_ready)
	);

	wewa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (tot_q),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	assign sample_stall       = !(state_q == ST_IDLE && tab_ready);
	assign cfg_ready          = 1'b1;
	assign result_valid       = result_valid_q;
	assign smoothed_frequency = out_freq_q;
	assign entries_held       = out_held_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(HISTORY_DEPTH)) else $error("history count beyond depth");
	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(oldest_q) < CNT_W'(HISTORY_DEPTH)) else $error("oldest slot out of ring");
	a_nosig_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && nosig_in) |=> (held_q == '0 && state_q == ST_DONE))
		else $error("no-signal word did not clear the history");
	a_held_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && entries_held != '0) |-> smoothed_frequency != '0)
		else $error("zero pitch reported with samples held");

endmodule

`default_nettype wire

FILE: hdl/wewa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wewa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/wewa_wtab.sv
// Weight table: fills a RAM with the exponential decay weights after reset.
`default_nettype none

module wewa_wtab (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [wewa_pkg::AGE_W-1:0] rd_addr,
	output logic      [wewa_pkg::WT_W-1:0]  rd_data,
	output logic                            ready
);
	import wewa_pkg::*;

	logic [AGE_W-1:0] fill_addr_q;
	logic             phase_q;
	logic             fill_done_q;
	logic [31:0]      v_q;
	logic [63:0]      prod_q;
	logic [32:0]      v_rnd;
	logic [63:0]      prod_rnd;
	logic [WT_W-1:0]  wt;
	logic             we;

	// Weight is the Q0.32 decay value rounded to Q0.16, saturated.
	always_comb begin
		v_rnd    = 33'(v_q) + 33'(32'h0000_8000);
		prod_rnd = prod_q + 64'h0000_0000_8000_0000;
		if (fill_addr_q == '0 || v_rnd[32]) begin
			wt = WT_MAX;
		end else begin
			wt = v_rnd[31:16];
		end
		we = !fill_done_q && !phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_addr_q <= '0;
			phase_q     <= 1'b0;
			fill_done_q <= 1'b0;
			v_q         <= DECAY_Q32;
		end else if (!fill_done_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				// Age zero takes the value one, saturated to WT_MAX; age one starts from the decay itself.
				if (fill_addr_q != '0) begin
					v_q <= prod_rnd[63:32];
				end
				fill_addr_q <= fill_addr_q + 1'b1;
				if (fill_addr_q == AGE_W'(AGE_SPAN - 1)) begin
					fill_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(v_q) * 64'(DECAY_Q32);
	end

	wewa_ram #(
		.WIDTH(WT_W),
		.DEPTH(AGE_SPAN)
	) u_wt_ram (
		.clk  (clk),
		.we   (we),
		.waddr(fill_addr_q),
		.wdata(wt),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign ready = fill_done_q;

endmodule

`default_nettype wire

FILE: hdl/wewa_div.sv
// Restoring divider producing one quotient bit per cycle.
`default_nettype none

module wewa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [wewa_pkg::SUM_W-1:0]  dividend,
	input  wire logic [wewa_pkg::TOT_W-1:0]  divisor,
	output logic      [wewa_pkg::FREQ_W-1:0] quotient,
	output wewa_pkg::div_stat_t              stat
);
	import wewa_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  div_q;
	logic [FREQ_W-1:0] lo_q;
	logic [FREQ_W-1:0] quo_q;
	logic [TOT_W:0]    trial;
	logic [TOT_W:0]    diff;
	logic              ge;

	// The quotient is known to fit FREQ_W bits, so the upper dividend bits
	// already form a partial remainder below the divisor.
	always_comb begin
		trial = {rem_q, lo_q[FREQ_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(FREQ_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:FREQ_W];
			lo_q  <= dividend[FREQ_W-1:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
			lo_q  <= {lo_q[FREQ_W-2:0], 1'b0};
			quo_q <= {quo_q[FREQ_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider busy and done together");

endmodule

`default_nettype wire

FILE: tb/sv/windowed_exp_weighted_average_core_test.sv
// Self-checking testbench of the windowed exponentially weighted pitch average core.
`timescale 1ns / 100ps

module windowed_exp_weighted_average_core_test;
	import wewa_pkg::*;

	// Spare register indexes. The block keeps no register there, so writes to them
	// must leave the window and the minimum count alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// The long receiver hold-off starts once this many sample words went in.
	localparam int unsigned HOLD_AT     = 440;
	localparam int unsigned HOLD_CYCLES = 400;
	// Quiet cycles after the last result word, well above one worst-case word.
	localparam int unsigned TAIL_CYCLES = 300;

	// Tracks the history ring, predicts each result word and checks the words that
	// come out of the block in order.
	class wewa_scoreboard;
		typedef struct packed {
			logic [FREQ_W-1:0]     pitch;
			logic [HELD_OUT_W-1:0] held;
		} avg_word_t;

		logic [FREQ_W-1:0] pitch_ring[HISTORY_DEPTH];
		logic [TIME_W-1:0] stamp_ring[HISTORY_DEPTH];
		logic [WT_W-1:0]   weight_lut[AGE_SPAN];
		int unsigned       oldest;
		int unsigned       held;
		logic [WIN_W-1:0]  window;
		logic [MINS_W-1:0] min_count;
		avg_word_t         pending_q[$];
		int unsigned       mismatches;
		int unsigned       accepted;

		function new();
			logic [63:0] decay;
			logic [63:0] w;
			decay = 64'(DECAY_Q32);
			decay = (64'd1 << 32);
			for (int a = 0; a < AGE_SPAN; a++) begin
				w = (decay + 64'd32768) >> 16;
				weight_lut[a] = (w > 64'd65535) ? WT_MAX : w[WT_W-1:0];
				decay = (decay * 64'(DECAY_Q32) + (64'd1 << 31)) >> 32;
			end
			oldest     = 0;
			held       = 0;
			window     = WINDOW_RESET;
			min_count  = MIN_RESET;
			mismatches = 0;
			accepted   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_WINDOW_MS) begin
				window = val[WIN_W-1:0];
			end else if (idx == REG_MIN_SAMPLES) begin
				min_count = val[MINS_W-1:0];
			end
		endfunction

		function void drop_oldest_sample();
			oldest = (oldest + 1) % HISTORY_DEPTH;
			held--;
		endfunction

		function logic [TIME_W-1:0] age_of(int unsigned s, logic [TIME_W-1:0] now);
			return now - stamp_ring[s];
		endfunction

		function void note_sample(logic signed [IN_FREQ_W-1:0] f, logic [TIME_W-1:0] now);
			avg_word_t   exp_w;
			logic [63:0] wsum;
			logic [63:0] wtot;
			logic [63:0] w;
			logic [TIME_W-1:0] age;
			int unsigned s;
			accepted++;
			if (f[IN_FREQ_W-1] || f == '0) begin
				// No signal: history is cleared and the word reads zero.
				held       = 0;
				oldest     = 0;
				exp_w.pitch = '0;
				exp_w.held  = '0;
			end else begin
				while (held > 0 && age_of(oldest, now) > TIME_W'(window)) begin
					drop_oldest_sample();
				end
				if (held >= HISTORY_DEPTH) begin
					drop_oldest_sample();
				end
				s = (oldest + held) % HISTORY_DEPTH;
				pitch_ring[s] = f[FREQ_W-1:0];
				stamp_ring[s] = now;
				held++;
				if (held < min_count) begin
					exp_w.pitch = f[FREQ_W-1:0];
				end else begin
					wsum = '0;
					wtot = '0;
					for (int i = 0; i < held; i++) begin
						s   = (oldest + i) % HISTORY_DEPTH;
						age = age_of(s, now);
						w   = (age < AGE_SPAN) ? 64'(weight_lut[age[AGE_W-1:0]]) : 64'd0;
						wsum += w * 64'(pitch_ring[s]);
						wtot += w;
					end
					exp_w.pitch = (wtot != 0) ? FREQ_W'(wsum / wtot) : f[FREQ_W-1:0];
				end
				exp_w.held = HELD_OUT_W'(held);
			end
			pending_q.push_back(exp_w);
		endfunction

		function void check_result(logic [FREQ_W-1:0] pitch, logic [HELD_OUT_W-1:0] count);
			avg_word_t exp_w;
			if (pending_q.size() == 0) begin
				$error("result word with no sample pending: smoothed_frequency %0d entries_held %0d",
					pitch, count);
				mismatches++;
				return;
			end
			exp_w = pending_q.pop_front();
			if (pitch !== exp_w.pitch) begin
				$error("smoothed_frequency: expected %0d, actual %0d", exp_w.pitch, pitch);
				mismatches++;
			end
			if (count !== exp_w.held) begin
				$error("entries_held: expected %0d, actual %0d", exp_w.held, count);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction
	endclass

	logic                          clk                = 1'b0;
	logic                          arst_n             = 1'b0;
	logic                          sample_valid       = 1'b0;
	logic                          sample_stall;
	logic signed [IN_FREQ_W-1:0]   frequency          = '0;
	logic        [TIME_W-1:0]      now_ms             = '0;
	logic                          result_valid;
	logic                          result_stall       = 1'b0;
	logic        [FREQ_W-1:0]      smoothed_frequency;
	logic        [HELD_OUT_W-1:0]  entries_held;
	logic                          cfg_valid          = 1'b0;
	logic                          cfg_ready;
	logic        [CFG_IDX_W-1:0]   cfg_index          = '0;
	logic        [CFG_DATA_W-1:0]  cfg_data           = '0;

	wewa_scoreboard sb;

	// Idle rates in percent per cycle; the main process changes them by phase.
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct  = 0;
	// Receiver hold-off bookkeeping, owned by the receiver process.
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	// Running millisecond clock of the pitch stream; it wraps like the real one.
	logic [TIME_W-1:0] stamp_ms;

	windowed_exp_weighted_average_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample_valid       (sample_valid),
		.sample_stall       (sample_stall),
		.frequency          (frequency),
		.now_ms             (now_ms),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.smoothed_frequency (smoothed_frequency),
		.entries_held       (entries_held),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver. Every edge it first takes in the word that this edge accepts, using
	// the values that stood before the edge, and then picks the next stall. Once in
	// the run it holds stall high for a long stretch while the sender keeps going,
	// so the output register fills, the next word finishes behind it and the block
	// has to stall its sample input.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(smoothed_frequency, entries_held);
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && sb.accepted >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Offers one sample word, after random idle cycles, and returns at the edge that
	// accepts it. Valid stays high so that a following word can go out back to back.
	task automatic send_sample(input logic signed [IN_FREQ_W-1:0] f,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		frequency    <= f;
		now_ms       <= now;
		do begin
			@(posedge clk);
		end while (sample_stall);
		sb.note_sample(f, now);
	endtask

	// One register write. Valid is only dropped after the last write of a group so it
	// never gets two assignments in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.set_reg(idx, val);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	// Every sample word gives exactly one result word, so an empty queue means the
	// block sits idle.
	task automatic wait_drained();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// New register setting between phases. The spare indexes get random data to show
	// that they are ignored and to toggle the upper index bit.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] win,
			input logic [CFG_DATA_W-1:0] mins);
		wait_drained();
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom), 1'b0);
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom), 1'b0);
		write_reg(REG_WINDOW_MS, win, 1'b0);
		write_reg(REG_MIN_SAMPLES, mins, 1'b1);
	endtask

	// Directed words at the reset setting: field extremes, the three no-signal forms,
	// a fill past the ring depth across the 32-bit wrap of the clock, aging that
	// empties the ring, and a timestamp that goes backwards so a held sample ends up
	// older than the weight table and gets weight zero.
	task automatic run_directed();
		logic [TIME_W-1:0] t0;
		t0 = 32'hFFFF_FFD0;
		send_sample(20'sd1, t0);
		send_sample(20'sh7FFFF, t0 + 10);
		send_sample(20'sd12345, t0 + 20);
		send_sample(20'sd0, t0 + 30);
		send_sample(-20'sd1, t0 + 32);
		send_sample(20'sh80000, t0 + 34);
		for (int k = 0; k < HISTORY_DEPTH + 1; k++) begin
			send_sample(IN_FREQ_W'(1000 * k + 777), t0 + 40 + k);
		end
		send_sample(20'sd5000, t0 + 656);
		send_sample(20'sd6000, t0 + 756);
		send_sample(20'sd7000, t0 + 706);
		sample_valid <= 1'b0;
		stamp_ms = t0 + 756;
	endtask

	// Random words. Most are valid pitches with short steps of the clock, so the ring
	// fills and the weighted mean is exercised; the rest are no-signal words, steps
	// past the window, backward steps and jumps to a random time.
	task automatic random_burst(input int unsigned count);
		logic signed [IN_FREQ_W-1:0] f;
		int unsigned pick;
		int unsigned span;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				f = '0;
			end else if (pick < 8) begin
				f = {1'b1, FREQ_W'($urandom)};
			end else if (pick < 20) begin
				f = {1'b0, FREQ_W'($urandom_range(1, 4095))};
			end else begin
				f = {1'b0, FREQ_W'($urandom_range(1, 524287))};
			end
			span = sb.window;
			pick = $urandom_range(99);
			if (pick < 78) begin
				stamp_ms = stamp_ms + $urandom_range(0, span / 6 + 1);
			end else if (pick < 87) begin
				stamp_ms = stamp_ms + span + $urandom_range(1, 400);
			end else if (pick < 93) begin
				stamp_ms = stamp_ms - $urandom_range(1, 300);
			end else if (pick < 97) begin
				stamp_ms = $urandom();
			end
			send_sample(f, stamp_ms);
		end
		sample_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles now and then, receiver mostly stalls.
		sender_idle_pct = 16;
		recv_stall_pct  = 82;
		run_directed();
		apply_setting(10'd1023, 10'd1);
		random_burst(70);
		apply_setting(10'd1, 10'd16);
		random_burst(60);
		// Window zero keeps only same-millisecond samples; minimum zero always averages.
		apply_setting(10'd0, 10'd0);
		random_burst(50);

		// Sender mostly idles, receiver stalls now and then.
		sender_idle_pct = 82;
		recv_stall_pct  = 16;
		// A minimum above the depth always passes the raw pitch through.
		apply_setting(10'd300, 10'd17);
		random_burst(60);
		apply_setting(10'd700, 10'd2);
		random_burst(90);

		// Neither side idles; the long hold-off lands in the last burst.
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		apply_setting(10'h3FF, 10'h3FF);
		random_burst(50);
		apply_setting(CFG_DATA_W'($urandom_range(1, 1023)), CFG_DATA_W'($urandom_range(1, 16)));
		random_burst(150);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("windowed_exp_weighted_average_core test passed");
		end else begin
			$display("windowed_exp_weighted_average_core test failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#(8_000_000);
		$display("windowed_exp_weighted_average_core test failed");
		$finish;
	end

endmodule
